[sv/xxh32_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers for the xxh32 stream core
package xxh32_pkg;

  localparam logic [31:0] P1 = 32'd2654435761;
  localparam logic [31:0] P2 = 32'd2246822519;
  localparam logic [31:0] P3 = 32'd3266489917;
  localparam logic [31:0] P4 = 32'd668265263;
  localparam logic [31:0] P5 = 32'd374761393;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  // one classified word as it sits in the queue
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;    // bytes to hash, already normalised to 0..4
    logic        last;
  } xxh32_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_LANE1,
    ST_LANE2,
    ST_MERGE,
    ST_WMUL,
    ST_WROT,
    ST_WACC,
    ST_BMUL,
    ST_BROT,
    ST_BACC,
    ST_AV1,
    ST_AV2,
    ST_OUT
  } xxh32_state_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    rol32 = (v << n) | (v >> (32 - n));
  endfunction

  // lane start values derived from the seed
  function automatic logic [31:0] lane_init(input logic [1:0] idx, input logic [31:0] seed);
    logic [31:0] r;
    r = seed;
    case (idx)
      2'd0:    r = seed + P1 + P2;
      2'd1:    r = seed + P2;
      2'd2:    r = seed;
      2'd3:    r = seed - P1;
      default: r = seed;
    endcase
    lane_init = r;
  endfunction

endpackage

[sv/xxh32_front.sv]
`timescale 1ns / 1ps
// input side: word classification and the queue towards the hash engine
module xxh32_front #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_word,
  input  logic [2:0]            in_count,
  input  logic                  in_last,
  output logic                  item_valid,
  output xxh32_pkg::xxh32_item_t item,
  input  logic                  item_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  xxh32_pkg::xxh32_item_t q_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          push;
  xxh32_pkg::xxh32_item_t cls;

  // a body word always counts as four bytes, a last word saturates at four
  always_comb begin
    cls.word = in_word;
    cls.last = in_last;
    if (!in_last || in_count > xxh32_pkg::FULL_COUNT) begin
      cls.cnt = xxh32_pkg::FULL_COUNT;
    end else begin
      cls.cnt = in_count;
    end
  end

  assign in_ready   = (count_r != (AW+1)'(DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count_r != '0);
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (item_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !item_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && item_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[sv/xxh32_back.sv]
`timescale 1ns / 1ps
// hash engine: stripe lanes, tail folding and avalanche on one shared multiplier
module xxh32_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           seed,
  input  logic                  item_valid,
  input  xxh32_pkg::xxh32_item_t item,
  output logic                  item_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata
);

  xxh32_pkg::xxh32_state_t state_r, state_nxt;

  logic [31:0] word_r;
  logic [1:0]  tail_r;
  logic        last_r;
  logic [1:0]  fill_r;
  logic [31:0] len_r;
  logic        seen_r;
  logic [1:0]  idx_r;
  logic [31:0] lane_r [4];
  logic [31:0] cand_r [3];
  logic [31:0] buf_r  [4];
  logic [31:0] acc_r;
  logic [31:0] mul_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] lane_base, merge_h, fin_h;
  logic        out_free;
  logic        buf_we, lane_step, acc_merge, acc_mul, idx_clr, idx_inc, out_ld;

  assign prod      = mul_a * mul_b;
  assign out_free  = !out_valid_r || out_tready;
  assign lane_base = seen_r ? lane_r[fill_r] : xxh32_pkg::lane_init(fill_r, seed);
  assign fin_h     = mul_r ^ (mul_r >> 16);

  always_comb begin
    if (seen_r) begin
      merge_h = xxh32_pkg::rol32(lane_r[0], 1) + xxh32_pkg::rol32(lane_r[1], 7)
              + xxh32_pkg::rol32(lane_r[2], 12) + xxh32_pkg::rol32(lane_r[3], 18);
    end else begin
      merge_h = seed + xxh32_pkg::P5;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xxh32_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (!item.last || item.cnt == xxh32_pkg::FULL_COUNT) begin
            state_nxt = xxh32_pkg::ST_PUSH;
          end else begin
            state_nxt = xxh32_pkg::ST_MERGE;
          end
        end
      end
      xxh32_pkg::ST_PUSH:  state_nxt = xxh32_pkg::ST_LANE1;
      xxh32_pkg::ST_LANE1: state_nxt = xxh32_pkg::ST_LANE2;
      xxh32_pkg::ST_LANE2: state_nxt = last_r ? xxh32_pkg::ST_MERGE : xxh32_pkg::ST_IDLE;
      xxh32_pkg::ST_MERGE: state_nxt = xxh32_pkg::ST_WMUL;
      xxh32_pkg::ST_WMUL:  state_nxt = (idx_r < fill_r) ? xxh32_pkg::ST_WROT : xxh32_pkg::ST_BMUL;
      xxh32_pkg::ST_WROT:  state_nxt = xxh32_pkg::ST_WACC;
      xxh32_pkg::ST_WACC:  state_nxt = xxh32_pkg::ST_WMUL;
      xxh32_pkg::ST_BMUL:  state_nxt = (idx_r < tail_r) ? xxh32_pkg::ST_BROT : xxh32_pkg::ST_AV1;
      xxh32_pkg::ST_BROT:  state_nxt = xxh32_pkg::ST_BACC;
      xxh32_pkg::ST_BACC:  state_nxt = xxh32_pkg::ST_BMUL;
      xxh32_pkg::ST_AV1:   state_nxt = xxh32_pkg::ST_AV2;
      xxh32_pkg::ST_AV2:   state_nxt = xxh32_pkg::ST_OUT;
      xxh32_pkg::ST_OUT:   state_nxt = out_free ? xxh32_pkg::ST_IDLE : xxh32_pkg::ST_OUT;
      default:             state_nxt = xxh32_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    item_pop  = 1'b0;
    buf_we    = 1'b0;
    lane_step = 1'b0;
    acc_merge = 1'b0;
    acc_mul   = 1'b0;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    out_ld    = 1'b0;
    case (state_r)
      xxh32_pkg::ST_IDLE: item_pop = item_valid;
      xxh32_pkg::ST_PUSH: begin
        buf_we = 1'b1;
        mul_a  = word_r;
        mul_b  = xxh32_pkg::P2;
      end
      xxh32_pkg::ST_LANE1: begin
        mul_a = xxh32_pkg::rol32(lane_base + mul_r, 13);
        mul_b = xxh32_pkg::P1;
      end
      xxh32_pkg::ST_LANE2: lane_step = 1'b1;
      xxh32_pkg::ST_MERGE: begin
        acc_merge = 1'b1;
        idx_clr   = 1'b1;
      end
      xxh32_pkg::ST_WMUL: begin
        mul_a = buf_r[idx_r];
        mul_b = xxh32_pkg::P3;
        if (!(idx_r < fill_r)) begin
          idx_clr = 1'b1;
        end
      end
      xxh32_pkg::ST_WROT: begin
        mul_a = xxh32_pkg::rol32(acc_r + mul_r, 17);
        mul_b = xxh32_pkg::P4;
      end
      xxh32_pkg::ST_WACC: begin
        acc_mul = 1'b1;
        idx_inc = 1'b1;
      end
      xxh32_pkg::ST_BMUL: begin
        mul_a = {24'd0, word_r[{idx_r, 3'b000} +: 8]};
        mul_b = xxh32_pkg::P5;
      end
      xxh32_pkg::ST_BROT: begin
        mul_a = xxh32_pkg::rol32(acc_r + mul_r, 11);
        mul_b = xxh32_pkg::P1;
      end
      xxh32_pkg::ST_BACC: begin
        acc_mul = 1'b1;
        idx_inc = 1'b1;
      end
      xxh32_pkg::ST_AV1: begin
        mul_a = acc_r ^ (acc_r >> 15);
        mul_b = xxh32_pkg::P2;
      end
      xxh32_pkg::ST_AV2: begin
        mul_a = mul_r ^ (mul_r >> 13);
        mul_b = xxh32_pkg::P3;
      end
      xxh32_pkg::ST_OUT: out_ld = out_free;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xxh32_pkg::ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      seen_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (item_pop) begin
        len_r <= len_r + 32'(item.cnt);
      end
      if (lane_step) begin
        if (fill_r == 2'd3) begin
          seen_r <= 1'b1;
        end
        fill_r <= fill_r + 1'b1;
      end
      if (idx_clr) begin
        idx_r <= '0;
      end else if (idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
        fill_r      <= '0;
        len_r       <= '0;
        seen_r      <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    // the finished product stays put while the hash waits for the output register
    if (state_r != xxh32_pkg::ST_OUT) begin
      mul_r <= prod;
    end
    if (item_pop) begin
      word_r <= item.word;
      last_r <= item.last;
      tail_r <= (item.cnt == xxh32_pkg::FULL_COUNT) ? 2'd0 : item.cnt[1:0];
    end
    if (buf_we) begin
      buf_r[fill_r] <= word_r;
    end
    if (lane_step) begin
      if (fill_r == 2'd3) begin
        lane_r[0] <= cand_r[0];
        lane_r[1] <= cand_r[1];
        lane_r[2] <= cand_r[2];
        lane_r[3] <= mul_r;
      end else begin
        cand_r[fill_r] <= mul_r;
      end
    end
    if (acc_merge) begin
      acc_r <= merge_h + len_r;
    end else if (acc_mul) begin
      acc_r <= mul_r;
    end
    if (out_ld) begin
      out_data_r <= fin_h;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/xxhash32_stream_core.sv]
`timescale 1ns / 1ps
// top level of the streaming xxh32 hash core
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: data_word[31:0], byte_count[34:32],
//          |     |                      |   zero pad[39:35]; in_tlast: last
//  out_    | out | out_tvalid/out_tready| out_tdata: hash[31:0]
//  cfg_    | in  | cfg_we               | cfg_wdata: seed[31:0]
//
// a body word goes through the hash engine in order: pop, multiply by prime 2,
// rotate and multiply by prime 1, lane update, all through the one shared multiplier
// the last word is merged, each buffered word and each tail byte folded in, then
// the avalanche runs; a four-byte last word takes the body path first
// the queue keeps taking words while not full, as the engine works or the hash waits
// reset clears the queue, message state and output valid; seed returns to 0
module xxhash32_stream_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // data_word[31:0], byte_count[34:32], pad
  input  logic        in_tlast,
  // hash results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // hash[31:0]
  // seed register
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]            seed_r;
  logic                   item_valid;
  logic                   item_pop;
  xxh32_pkg::xxh32_item_t item;

  // the user must write the seed only between messages; the core does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // front: classify each word and queue it
  xxh32_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_word    (in_tdata[31:0]),
    .in_count   (in_tdata[34:32]),
    .in_last    (in_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // back: lanes, tail folding, avalanche and the output register
  xxh32_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/xxh32_checker.sv]
`timescale 1ns / 1ps
// checker for the xxh32 stream core: predicts each hash and compares it with the core
module xxh32_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,    // data_word[31:0], byte_count[34:32], pad
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // hash[31:0]
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        end_of_run,
  output int          mismatch_count,
  output int          hashes_due
);

  // predicted message state
  logic [31:0] seed_now;
  logic [31:0] lane [4];
  logic [31:0] stripe [4];
  logic [2:0]  fill;
  logic [31:0] msg_len;
  logic        seen;

  logic [31:0] hash_q [$];
  logic [31:0] want_hash;
  logic [31:0] new_hash;
  logic        end_done;
  int          errs;

  assign mismatch_count = errs;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errs++;
    $display("%0t ns: %s, expected %08h, got %08h", $time, what, want, got);
  endtask

  task automatic start_lanes();
    lane[0] = seed_now + xxh32_pkg::P1 + xxh32_pkg::P2;
    lane[1] = seed_now + xxh32_pkg::P2;
    lane[2] = seed_now;
    lane[3] = seed_now - xxh32_pkg::P1;
  endtask

  task automatic clear_message();
    fill    = 3'd0;
    msg_len = 32'd0;
    seen    = 1'b0;
    start_lanes();
  endtask

  // buffer one word, run the four lanes once a stripe is full
  task automatic absorb_word(input logic [31:0] w);
    int i;
    stripe[fill[1:0]] = w;
    fill = fill + 3'd1;
    if (fill == 3'd4) begin
      if (!seen) start_lanes();
      for (i = 0; i < 4; i++)
        lane[i] = rotl(lane[i] + stripe[i] * xxh32_pkg::P2, 13) * xxh32_pkg::P1;
      fill = 3'd0;
      seen = 1'b1;
    end
  endtask

  // last word: merge, fold leftovers and tail bytes, avalanche
  task automatic close_message(input logic [31:0] w, input logic [2:0] cnt,
                               output logic [31:0] h);
    logic [2:0]  n;
    logic [31:0] acc;
    int          i;
    n = (cnt > xxh32_pkg::FULL_COUNT) ? xxh32_pkg::FULL_COUNT : cnt;
    msg_len = msg_len + n;
    if (n == xxh32_pkg::FULL_COUNT) begin
      absorb_word(w);
      n = 3'd0;
    end
    if (seen)
      acc = rotl(lane[0], 1) + rotl(lane[1], 7) + rotl(lane[2], 12) + rotl(lane[3], 18);
    else
      acc = seed_now + xxh32_pkg::P5;
    acc = acc + msg_len;
    for (i = 0; i < fill; i++)
      acc = rotl(acc + stripe[i] * xxh32_pkg::P3, 17) * xxh32_pkg::P4;
    for (i = 0; i < n; i++)
      acc = rotl(acc + w[8*i +: 8] * xxh32_pkg::P5, 11) * xxh32_pkg::P1;
    acc = acc ^ (acc >> 15);
    acc = acc * xxh32_pkg::P2;
    acc = acc ^ (acc >> 13);
    acc = acc * xxh32_pkg::P3;
    acc = acc ^ (acc >> 16);
    h = acc;
    clear_message();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_now = 32'd0;
      for (int i = 0; i < 4; i++) stripe[i] = 32'd0;
      clear_message();
      hash_q.delete();
      end_done = 1'b0;
    end else begin
      if (cfg_we) seed_now = cfg_wdata;
      if (in_tvalid && in_tready) begin
        if (in_tlast) begin
          close_message(in_tdata[31:0], in_tdata[34:32], new_hash);
          hash_q.push_back(new_hash);
        end else begin
          msg_len = msg_len + 32'd4;
          absorb_word(in_tdata[31:0]);
        end
      end
      if (out_tvalid && out_tready) begin
        if (hash_q.size() == 0) begin
          report("hash with none outstanding", 32'd0, out_tdata);
        end else begin
          want_hash = hash_q.pop_front();
          if (out_tdata !== want_hash) report("hash mismatch", want_hash, out_tdata);
        end
      end
      if (end_of_run && !end_done) begin
        end_done = 1'b1;
        if (hash_q.size() != 0) report("hash never delivered", hash_q[0], 32'd0);
      end
    end
    hashes_due = hash_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench top: drives messages and seed writes into the xxh32 core and gives the verdict
module testbench;

  localparam int HALF_PERIOD    = 6;
  localparam int HOLD_OFF       = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_ITEMS = 25;
  localparam int ITEM_GOAL      = 1150;
  localparam int PHASES         = 5;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;      // data_word[31:0], byte_count[34:32], pad
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // hash[31:0]
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_wdata  = '0;
  logic        end_of_run = 1'b0;

  int mismatch_count;
  int hashes_due;
  int burst_left  = 0;
  int items_sent  = 0;
  int rx_tick     = 0;
  int stall_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  xxhash32_stream_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  xxh32_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .end_of_run     (end_of_run),
    .mismatch_count (mismatch_count),
    .hashes_due     (hashes_due)
  );

  // hash receiver: steps through ready patterns as rx_tick counts up, so that
  // back-pressure lands on every part of the core's work
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[8:6])
      3'd0, 3'd1: out_tready <= 1'b1;
      3'd2, 3'd3: out_tready <= ($urandom_range(0, 1) == 0);
      3'd4:       out_tready <= ($urandom_range(0, 3) == 0);
      3'd5:       out_tready <= (rx_tick[2:0] != 3'd0);
      3'd6:       out_tready <= rx_tick[4];
      default:    out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // watchdog: any word moving on either channel, or a seed write, counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // one input word; valid stays high across a burst, gaps open between bursts
  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, cnt, w};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  // stop sending and wait until every predicted hash has come out
  task automatic wait_for_hashes();
    if (burst_left != 0) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
    end
    while (hashes_due != 0) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    wait_for_hashes();
    repeat (HOLD_OFF) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly random words, now and then an all-zero or all-one word
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // well-formed message of random length; body byte counts are noise, the
  // last count covers 0..7 so both the tail and the saturating case appear
  task automatic send_random_message();
    int nwords;
    int k;
    int sel;
    sel = $urandom_range(0, 15);
    if (sel <= 7)
      nwords = $urandom_range(1, 4);
    else if (sel <= 12)
      nwords = $urandom_range(5, 12);
    else if (sel <= 14)
      nwords = $urandom_range(13, 24);
    else
      nwords = $urandom_range(25, 60);
    for (k = 0; k < nwords - 1; k++) send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin
    int p;
    int target;
    logic [31:0] s;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under seed zero
    write_seed(32'h0000_0000);
    // empty message
    send_word(32'h0000_0000, 3'd0, 1'b1);
    // one-word messages with 1..4 bytes, bits above the count set
    for (int c = 1; c <= 4; c++) send_word(32'hFFFF_FFFF, 3'(c), 1'b1);
    // byte count above four saturates
    send_word(32'h0123_4567, 3'd7, 1'b1);
    // exactly one stripe, closed by a full last word
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    // counts on body words are ignored
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'h0000_0000, 3'd6, 1'b0);
    send_word(32'hDEAD_BEEF, 3'd5, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b0);
    send_word(32'h1234_5678, 3'd2, 1'b1);
    // a stripe, two leftover words and a three-byte tail
    for (int k = 0; k < 6; k++) send_word(pick_word(), 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
    // non-empty message closed by a last word holding no bytes
    send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
    send_word(32'h8000_0001, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);

    // random phases, each under its own seed, extremes included
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       s = 32'hFFFF_FFFF;
        2:       s = 32'h0000_0000;
        default: s = $urandom;
      endcase
      write_seed(s);
      target = items_sent + (ITEM_GOAL - DIRECTED_ITEMS) / PHASES;
      while (items_sent < target) begin
        send_random_message();
        // let the core run dry now and then
        if ($urandom_range(0, 15) == 0) wait_for_hashes();
      end
    end

    wait_for_hashes();
    repeat (HOLD_OFF) @(negedge clk);
    end_of_run <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (mismatch_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
